FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL.
// Define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/si2f_pkg.sv
// Types and constants for the scaled int to float32 converter.
// No dependencies.
package si2f_pkg;
  localparam int unsigned ValW  = 17;
  localparam int unsigned ScW   = 9;
  localparam int unsigned MagW  = 17;
  localparam int unsigned LeadW = 5;
  localparam int unsigned ExpW  = 11;
  localparam logic [31:0] InfBits = 32'h7f80_0000;
  localparam int ExpBias = 127;

  typedef struct packed {
    logic              sign;
    logic              zero;
    logic [MagW-1:0]   mag;
    logic [ScW-1:0]    scale;
  } s1_t;

  typedef struct packed {
    logic              sign;
    logic              zero;
    logic [MagW-1:0]   mag;
    logic [LeadW-1:0]  lead;
    logic [ExpW-1:0]   bexp;
  } s2_t;
endpackage

FILE: sv/si2f_front.sv
// Stage logic: sign split, magnitude, leading-one position and biased exponent.
// Depends on si2f_pkg.
module si2f_front (
  input  logic signed [si2f_pkg::ValW-1:0] value_i,
  input  logic signed [si2f_pkg::ScW-1:0]  scale_i,
  output si2f_pkg::s1_t                    s1_o,
  input  si2f_pkg::s1_t                    s1_i,
  output si2f_pkg::s2_t                    s2_o
);
  logic [si2f_pkg::MagW-1:0] mag;
  logic [si2f_pkg::LeadW-1:0] lead;

  assign mag = value_i[si2f_pkg::ValW-1] ? (~value_i + 17'd1) : value_i;
  assign s1_o.sign  = value_i[si2f_pkg::ValW-1];
  assign s1_o.zero  = (value_i == '0);
  assign s1_o.mag   = mag;
  assign s1_o.scale = scale_i;

  always_comb begin
    lead = '0;
    for (int i = 0; i < si2f_pkg::MagW; i++) begin
      if (s1_i.mag[i]) lead = si2f_pkg::LeadW'(i);
    end
  end

  assign s2_o.sign = s1_i.sign;
  assign s2_o.zero = s1_i.zero;
  assign s2_o.mag  = s1_i.mag;
  assign s2_o.lead = lead;
  assign s2_o.bexp = si2f_pkg::ExpW'(signed'({1'b0, lead})) +
                     si2f_pkg::ExpW'(si2f_pkg::ExpBias) +
                     si2f_pkg::ExpW'(signed'(s1_i.scale));
endmodule

FILE: sv/si2f_pack.sv
// Stage logic: zero, overflow to infinity, normal packing or subnormal shift with round to nearest even.
// Depends on si2f_pkg.
module si2f_pack (
  input  si2f_pkg::s2_t s2_i,
  output logic [31:0]   bits_o
);
  logic signed [si2f_pkg::ExpW-1:0] bexp;
  logic signed [si2f_pkg::ExpW-1:0] k;
  logic [4:0]  d;
  logic [22:0] frac_n;
  logic [40:0] wide;
  logic [16:0] q, rem, half;
  logic [23:0] frac_s;
  logic        up;

  assign bexp = signed'(s2_i.bexp);
  assign k    = bexp - 11'sd1 + 11'sd23 - signed'(11'({6'd0, s2_i.lead}));
  // k here = scale + 149
  assign frac_n = 23'(({6'd0, s2_i.mag}) << (5'd23 - s2_i.lead));

  always_comb begin
    d = '0; q = '0; rem = '0; half = '0; wide = '0; up = 1'b0; frac_s = '0;
    if (k >= 0) begin
      wide   = 41'(s2_i.mag) << k[4:0];
      frac_s = wide[23:0];
    end else if (k > -11'sd18) begin
      d      = 5'(-k);
      q      = s2_i.mag >> d;
      rem    = s2_i.mag & ((17'd1 << d) - 17'd1);
      half   = 17'd1 << (d - 5'd1);
      up     = (rem > half) || ((rem == half) && q[0]);
      frac_s = 24'(q) + 24'(up);
    end
  end

  always_comb begin
    if (s2_i.zero) bits_o = '0;
    else if (bexp >= 11'sd255) bits_o = {s2_i.sign, 31'd0} | si2f_pkg::InfBits;
    else if (bexp > 11'sd0) bits_o = {s2_i.sign, bexp[7:0], frac_n};
    else bits_o = {s2_i.sign, 7'd0, frac_s};
  end
endmodule

FILE: sv/scaled_int_to_float32_core.sv
// Scaled integer to float32 converter, top level with three-stage pipeline.
// Depends on si2f_pkg, si2f_front, si2f_pack, assert_macros.svh.
//
// Usage:
//   Input channel value_i/scale_i with valid_i/ready_o; output channel
//   float_bits_o with valid_o/ready_i. A transfer happens when valid and
//   ready are both high at a rising clock edge.
//   Stage 1 registers sign and magnitude, stage 2 the leading-one
//   position and biased exponent, stage 3 the packed result.
//   Throughput is one item per cycle while the receiver does not stall; each
//   stage advances when the stage after it is empty or moving.
//   When the receiver stalls the pipeline fills and ready_o drops once the
//   output stage and all inner stages hold items; nothing is lost.
//   Reset (rst_ni low, asynchronous) empties all stages.
`include "assert_macros.svh"
module scaled_int_to_float32_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  logic signed [si2f_pkg::ValW-1:0] value_i,
  input  logic signed [si2f_pkg::ScW-1:0]  scale_i,
  output logic                             valid_o,
  input  logic                             ready_i,
  output logic [31:0]                      float_bits_o
);
  si2f_pkg::s1_t s1_d, s1_q;
  si2f_pkg::s2_t s2_d, s2_q;
  logic [31:0]   out_d, out_q;
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  assign en3 = !v3_q || ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign ready_o = en1;

  si2f_front u_front (.value_i, .scale_i, .s1_o(s1_d), .s1_i(s1_q), .s2_o(s2_d));
  si2f_pack  u_pack  (.s2_i(s2_q), .bits_o(out_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) s1_q <= s1_d;
    if (en2 && v1_q) s2_q <= s2_d;
    if (en3 && v2_q) out_q <= out_d;
  end

  assign valid_o      = v3_q;
  assign float_bits_o = out_q;

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, valid_o && !ready_i, valid_o && $stable(float_bits_o))
  `ASSERT_IMPL(a_ready_full, clk_i, rst_ni, !ready_o |-> (v1_q && v2_q && v3_q && !ready_i))
  `ASSERT_NEXT(a_zero_out, clk_i, rst_ni, en3 && v2_q && s2_q.zero, float_bits_o == 32'd0)
endmodule

FILE: sim/tb_scaled_int_to_float32_core.sv
// Testbench for scaled_int_to_float32_core: drives value/scale pairs, predicts
// the float32 bit pattern of value * 2^scale and checks each output transfer.
// Depends on si2f_pkg and the converter RTL.
`timescale 1ns / 100ps
module tb_scaled_int_to_float32_core;
  typedef logic [si2f_pkg::ValW-1:0] val_t;
  typedef logic [si2f_pkg::ScW-1:0]  sc_t;

  localparam int CycleLimit = 200000;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             valid_i = 1'b0;
  logic                             ready_o;
  logic signed [si2f_pkg::ValW-1:0] value_i = '0;
  logic signed [si2f_pkg::ScW-1:0]  scale_i = '0;
  logic                             valid_o;
  logic                             ready_i = 1'b0;
  logic [31:0]                      float_bits_o;

  logic [31:0] float_queue[$];
  int          mismatches = 0;
  int          checked = 0;
  int          sent = 0;
  int          cycles = 0;
  int          hold_off = 0;
  bit          failed = 1'b0;

  scaled_int_to_float32_core i_dut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_scaled_int_to_float32_core: FAIL");
      $finish;
    end
  end

  function automatic logic [31:0] scaled_to_float(val_t v, sc_t s);
    logic [31:0] sgn;
    logic [31:0] mag;
    logic [31:0] q;
    logic [31:0] rem;
    logic [31:0] half;
    int          sc;
    int          lead;
    int          bexp;
    int          k;
    sgn = v[si2f_pkg::ValW-1] ? 32'h8000_0000 : 32'h0;
    sc = $signed(s);
    mag = v[si2f_pkg::ValW-1] ? ((32'h2_0000 - {15'b0, v}) & 32'h1_ffff) : {15'b0, v};
    if (mag == 0) return 32'h0;
    lead = -1;
    for (int i = 0; i < 18; i++) if (mag[i]) lead = i;
    bexp = lead + si2f_pkg::ExpBias + sc;
    if (bexp >= 255) return sgn | si2f_pkg::InfBits;
    if (bexp > 0) return sgn | (32'(bexp) << 23) | ((mag << (23 - lead)) & 32'h007f_ffff);
    k = sc + 149;
    if (k >= 0) return sgn | (mag << k);
    k = -k;
    if (k >= 18) return sgn;
    q = mag >> k;
    rem = mag & ((32'h1 << k) - 1);
    half = 32'h1 << (k - 1);
    if (rem > half || (rem == half && q[0])) q = q + 1;
    return sgn | q;
  endfunction

  // Output side: random wait per result, plus a long hold-off when requested.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, 8);
      repeat (gap) begin
        @(negedge clk_i);
        ready_i <= 1'b0;
      end
      while (hold_off > 0) begin
        @(negedge clk_i);
        ready_i <= 1'b0;
        hold_off = hold_off - 1;
      end
      @(negedge clk_i);
      ready_i <= 1'b1;
      do @(posedge clk_i); while (!valid_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o && ready_i) begin
      if (float_queue.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: %h", float_bits_o);
      end else begin
        logic [31:0] exp_bits;
        exp_bits = float_queue.pop_front();
        checked++;
        if (exp_bits !== float_bits_o) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h got %h", exp_bits, float_bits_o);
        end
      end
    end
  end

  // Leaves valid_i high after the transfer so the next item can follow at once.
  task automatic send_item(val_t v, sc_t s, bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 8) : 0);
    repeat (gap) begin
      @(negedge clk_i);
      valid_i <= 1'b0;
    end
    @(negedge clk_i);
    valid_i <= 1'b1;
    value_i <= v;
    scale_i <= s;
    do @(posedge clk_i); while (!ready_o);
    float_queue.push_back(scaled_to_float(v, s));
    sent++;
  endtask

  task automatic test_directed();
    int vals[8] = '{0, 1, -1, 65535, -65535, -65536, 3, 5};
    int scs[8]  = '{0, -160, 60, -149, -150, -126, 255, -256};
    for (int i = 0; i < 8; i++) send_item(val_t'(vals[i]), sc_t'(scs[i]));
    send_item(val_t'(3), sc_t'(-150));    // tie rounds up to even
    send_item(val_t'(10), sc_t'(-151));   // tie rounds down to even
    send_item(val_t'(65535), sc_t'(-165)); // rounds up to the smallest subnormal
    send_item(val_t'(1), sc_t'(-151));    // below half the smallest subnormal
    send_item(val_t'(-1), sc_t'(-151));   // signed zero
    send_item(val_t'(1), sc_t'(-150));    // exact half, rounds to zero
    send_item(val_t'(65535), sc_t'(200)); // overflow to infinity
    send_item(val_t'(-2), sc_t'(128));
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      val_t v;
      sc_t  s;
      v = val_t'($urandom);
      case ($urandom_range(0, 3))
        0: s = sc_t'($urandom);
        1: s = sc_t'($urandom_range(0, 40) - 170);
        2: s = sc_t'($urandom_range(0, 220) - 160);
        default: s = sc_t'($urandom_range(0, 20) - 155);
      endcase
      send_item(v, s);
    end
  endtask

  // Receiver stops for a long stretch while the sender keeps offering.
  task automatic test_backpressure();
    hold_off = 60;
    for (int i = 0; i < 30; i++) send_item(val_t'($urandom), sc_t'($urandom), 1'b1);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(900);
    test_backpressure();
    test_random(900);
    @(negedge clk_i);
    valid_i <= 1'b0;
    while (float_queue.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("sent %0d items, checked %0d results, %0d mismatches", sent, checked, mismatches);
    $display("covered zero, extremes, subnormal rounding, underflow, overflow, stalls");
    if (!failed && float_queue.size() == 0) begin
      $display("tb_scaled_int_to_float32_core: PASS");
    end else begin
      $display("tb_scaled_int_to_float32_core: FAIL");
    end
    $finish;
  end
endmodule

FILE: scaled_int_to_float32_core.f
+incdir+sv
sv/si2f_pkg.sv
sv/si2f_front.sv
sv/si2f_pack.sv
sv/scaled_int_to_float32_core.sv
sim/tb_scaled_int_to_float32_core.sv
